// ----- hdl/aho_corasick_matcher_top_macros.svh -----
// assertion macros for the pattern matcher
`ifndef AHO_CORASICK_MATCHER_TOP_MACROS_SVH
`define AHO_CORASICK_MATCHER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ACM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ACM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ACM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ACM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/acm_pkg.sv -----
// shared types and command codes for the pattern matcher
`default_nettype none
package acm_pkg;
   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_END_WORD = 3'd1;
   localparam logic [2:0] CMD_BUILD = 3'd2;
   localparam logic [2:0] CMD_SCAN = 3'd3;
   localparam logic [2:0] CMD_END_TEXT = 3'd4;
   typedef struct packed {
      logic [2:0] command;
      logic [7:0] symbol;
   } req_type;
   typedef struct packed {
      logic matched;
      logic status;
   } rsp_type;
endpackage
`default_nettype wire

// ----- hdl/acm_stream_if.sv -----
// valid/ready channel carrying one payload
`default_nettype none
interface acm_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/acm_ram.sv -----
// generic simple dual port ram (one write port, one read port) with registered read
`default_nettype none
module acm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/aho_corasick_matcher_top.sv -----
// Trie pattern matcher: one command accepted at a time, one response per command.
// Each child lookup sweeps the allocated nodes through one shared compare unit reading the
// node table, node by node (address, then compare). An insert is one lookup followed by a
// dispatch step and the response. A scan is one lookup per failure link followed, each hop
// adding a link read, plus the end mark read. Build makes a full pass over the node table
// for every queued node, plus a failure walk and an end mark step per child. A waiting
// response does not block the next request, only the next response. After reset a
// clearing pass over all NODE_COUNT entries empties the end marks before the first request
// is taken.
`default_nettype none
`include "aho_corasick_matcher_top_macros.svh"
module aho_corasick_matcher_top
   import acm_pkg::*;
#(
   parameter int NODE_COUNT = 256
) (
   input wire logic clock,
   input wire logic reset,
   acm_stream_if.sink   req,
   acm_stream_if.source rsp
);
   localparam int AW = $clog2(NODE_COUNT);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] FULL = CW'(NODE_COUNT);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SWEEP = 4'd2, S_SWEEP_W = 4'd3,
      S_DISPATCH = 4'd4, S_FAILRD = 4'd5, S_FAILW = 4'd6, S_ENDRD = 4'd7, S_ENDW = 4'd8,
      S_RESP = 4'd9, S_BSEED = 4'd10, S_BPOP = 4'd11, S_BPOPW = 4'd12, S_BSCAN = 4'd13,
      S_BSCANW = 4'd14, S_BEND = 4'd15;
   // lookup owner codes
   localparam logic [1:0] L_INS = 2'd0, L_SCAN = 2'd1, L_BLD = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] owner_ff, owner_in;
   req_type cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] icur_ff, icur_in, mcur_ff, mcur_in;
   logic seen_ff, seen_in, status_ff, status_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] key_ff, key_in;
   logic [7:0] sym_ff, sym_in;
   logic [AW-1:0] found_ff, found_in;
   logic hit_ff, hit_in;
   logic [CW:0] guard_ff, guard_in;
   logic [CW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0] cur_ff, cur_in, node_ff, node_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // ram ports
   logic par_we, sym_we, fail_we, end_we, q_we;
   logic [AW-1:0] par_wa, sym_wa, fail_wa, end_wa, q_wa;
   logic [AW-1:0] par_wd, fail_wd, q_wd;
   logic [7:0] sym_wd;
   logic end_wd;
   logic [AW-1:0] tab_ra, fail_ra, end_ra, q_ra;
   logic [AW-1:0] par_rd, fail_rd, q_rd;
   logic [7:0] sym_rd;
   logic end_rd;

   acm_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_par (.clock, .wr_en(par_we), .wr_addr(par_wa),
      .wr_data(par_wd), .rd_addr(tab_ra), .rd_data(par_rd));
   acm_ram #(.WIDTH(8), .DEPTH(NODE_COUNT)) u_sym (.clock, .wr_en(sym_we), .wr_addr(sym_wa),
      .wr_data(sym_wd), .rd_addr(tab_ra), .rd_data(sym_rd));
   acm_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_fail (.clock, .wr_en(fail_we),
      .wr_addr(fail_wa), .wr_data(fail_wd), .rd_addr(fail_ra), .rd_data(fail_rd));
   acm_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_end (.clock, .wr_en(end_we), .wr_addr(end_wa),
      .wr_data(end_wd), .rd_addr(end_ra), .rd_data(end_rd));
   acm_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_q (.clock, .wr_en(q_we), .wr_addr(q_wa),
      .wr_data(q_wd), .rd_addr(q_ra), .rd_data(q_rd));

   // shared compare unit: match the node just read against the lookup key
   logic cmp_hit;
   assign cmp_hit = (par_rd == key_ff) && (sym_rd == sym_ff);
   logic [AW-1:0] idx_a;
   assign idx_a = idx_ff[AW-1:0];

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; owner_in = owner_ff; cmd_in = cmd_ff; count_in = count_ff;
      icur_in = icur_ff; mcur_in = mcur_ff; seen_in = seen_ff; status_in = status_ff;
      idx_in = idx_ff; key_in = key_ff; sym_in = sym_ff; found_in = found_ff; hit_in = hit_ff;
      guard_in = guard_ff; head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff;
      node_in = node_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      par_we = 1'b0; sym_we = 1'b0; fail_we = 1'b0; end_we = 1'b0; q_we = 1'b0;
      par_wa = icur_ff; par_wd = icur_ff; sym_wa = icur_ff; sym_wd = sym_ff;
      fail_wa = node_ff; fail_wd = '0; end_wa = idx_a; end_wd = 1'b0;
      q_wa = tail_ff[AW-1:0]; q_wd = idx_a;
      tab_ra = idx_a; fail_ra = key_ff; end_ra = mcur_ff; q_ra = head_ff[AW-1:0];
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            end_we = 1'b1; end_wa = idx_a; end_wd = 1'b0;
            idx_in = idx_ff + CW'(1);
            if (idx_ff == FULL - CW'(1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.data; status_in = 1'b0; sym_in = req.data.symbol;
               guard_in = '0;
               case (req.data.command)
                  CMD_INSERT: begin
                     owner_in = L_INS; key_in = icur_ff; idx_in = CW'(1); hit_in = 1'b0;
                     state_in = S_SWEEP;
                  end
                  CMD_END_WORD: begin
                     if (icur_ff != '0) begin
                        end_we = 1'b1; end_wa = icur_ff; end_wd = 1'b1; icur_in = '0;
                     end
                     state_in = S_RESP;
                  end
                  CMD_BUILD: begin
                     fail_we = 1'b1; fail_wa = '0; fail_wd = '0;
                     head_in = '0; tail_in = '0; idx_in = CW'(1);
                     state_in = S_BSEED;
                  end
                  CMD_SCAN: begin
                     owner_in = L_SCAN; key_in = mcur_ff; idx_in = CW'(1); hit_in = 1'b0;
                     state_in = S_SWEEP;
                  end
                  CMD_END_TEXT: begin
                     mcur_in = '0; state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         // child search: issue a read per node, compare it in the next cycle
         S_SWEEP: begin
            if (idx_ff >= count_ff) state_in = S_DISPATCH;
            else begin
               tab_ra = idx_a; found_in = idx_a; state_in = S_SWEEP_W;
            end
         end
         S_SWEEP_W: begin
            if (cmp_hit) begin
               hit_in = 1'b1; state_in = S_DISPATCH;
            end else begin
               idx_in = idx_ff + CW'(1); state_in = S_SWEEP;
            end
         end
         S_DISPATCH: begin
            case (owner_ff)
               L_INS: begin
                  if (hit_ff) icur_in = found_ff;
                  else if (count_ff >= FULL) status_in = 1'b1;
                  else begin
                     par_we = 1'b1; par_wa = count_ff[AW-1:0]; par_wd = icur_ff;
                     sym_we = 1'b1; sym_wa = count_ff[AW-1:0]; sym_wd = sym_ff;
                     end_we = 1'b1; end_wa = count_ff[AW-1:0]; end_wd = 1'b0;
                     icur_in = count_ff[AW-1:0]; count_in = count_ff + CW'(1);
                  end
                  state_in = S_RESP;
               end
               L_SCAN: begin
                  if (!hit_ff && key_ff != '0 && guard_ff < (CW+1)'(NODE_COUNT)) begin
                     fail_ra = key_ff; state_in = S_FAILRD;
                  end else begin
                     if (hit_ff) mcur_in = found_ff;
                     else mcur_in = key_ff;
                     state_in = S_ENDRD;
                  end
               end
               default: begin
                  if (!hit_ff && key_ff != '0 && guard_ff < (CW+1)'(NODE_COUNT)) begin
                     fail_ra = key_ff; state_in = S_FAILRD;
                  end else begin
                     fail_we = 1'b1; fail_wa = node_ff;
                     fail_wd = (hit_ff && found_ff != node_ff) ? found_ff : '0;
                     found_in = fail_wd;
                     state_in = S_BEND;
                  end
               end
            endcase
         end
         S_FAILRD: state_in = S_FAILW;
         S_FAILW: begin
            key_in = fail_rd; guard_in = guard_ff + (CW+1)'(1); idx_in = CW'(1);
            hit_in = 1'b0; state_in = S_SWEEP;
         end
         S_ENDRD: begin
            end_ra = mcur_ff; state_in = S_ENDW;
         end
         S_ENDW: begin
            if (end_rd) seen_in = 1'b1;
            state_in = S_RESP;
         end
         // hold until the previous response has gone
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.matched = seen_ff;
               rsp_in.status = status_ff;
               if (cmd_ff.command == CMD_END_TEXT) seen_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         // build: queue depth one children of the root
         S_BSEED: begin
            if (idx_ff >= count_ff) begin
               state_in = S_BPOP;
            end else begin
               tab_ra = idx_a; state_in = S_BSCANW; owner_in = L_INS;
            end
         end
         S_BPOP: begin
            if (head_ff >= tail_ff) state_in = S_RESP;
            else begin
               q_ra = head_ff[AW-1:0]; head_in = head_ff + CW'(1); state_in = S_BPOPW;
            end
         end
         S_BPOPW: begin
            cur_in = q_rd; idx_in = CW'(1); state_in = S_BSCAN; owner_in = L_BLD;
         end
         S_BSCAN: begin
            if (idx_ff >= count_ff) state_in = S_BPOP;
            else begin
               tab_ra = idx_a; state_in = S_BSCANW;
            end
         end
         S_BSCANW: begin
            if (owner_ff == L_INS) begin
               if (par_rd == '0) begin
                  fail_we = 1'b1; fail_wa = idx_a; fail_wd = '0;
                  q_we = 1'b1; q_wa = tail_ff[AW-1:0]; q_wd = idx_a;
                  tail_in = tail_ff + CW'(1);
               end
               idx_in = idx_ff + CW'(1); state_in = S_BSEED;
            end else if (par_rd == cur_ff) begin
               node_in = idx_a; sym_in = sym_rd; guard_in = '0;
               fail_ra = cur_ff; key_in = cur_ff; state_in = S_FAILRD; owner_in = L_BLD;
            end else begin
               idx_in = idx_ff + CW'(1); state_in = S_BSCAN;
            end
         end
         // propagate the end mark of the failure target (read first, then fold in) and queue the node
         S_BEND: begin
            end_ra = found_ff;
            key_in = node_ff;
            if (key_ff == node_ff) begin
               if (end_rd) begin
                  end_we = 1'b1; end_wa = node_ff; end_wd = 1'b1;
               end
               if (tail_ff < FULL) begin
                  q_we = 1'b1; q_wa = tail_ff[AW-1:0]; q_wd = node_ff;
                  tail_in = tail_ff + CW'(1);
               end
               idx_in = CW'(node_ff) + CW'(1);
               state_in = S_BSCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; idx_ff <= '0; count_ff <= CW'(1); icur_ff <= '0; mcur_ff <= '0;
         seen_ff <= 1'b0; rsp_valid_ff <= 1'b0; owner_ff <= L_INS;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; count_ff <= count_in; icur_ff <= icur_in;
         mcur_ff <= mcur_in; seen_ff <= seen_in; rsp_valid_ff <= rsp_valid_in;
         owner_ff <= owner_in;
      end
   end
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; status_ff <= status_in; key_ff <= key_in; sym_ff <= sym_in;
      found_ff <= found_in; hit_ff <= hit_in; guard_ff <= guard_in; head_ff <= head_in;
      tail_ff <= tail_in; cur_ff <= cur_in; node_ff <= node_in; rsp_ff <= rsp_in;
   end

   `ACM_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE)
   `ACM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= FULL && count_ff != '0)
   `ACM_ASSERT_NXT(a_take_busy, clock, reset, req.valid && req.ready, !req.ready)
endmodule
`default_nettype wire

// ----- tb/acm_checker.sv -----
// response checker for the pattern matcher: predicts each response and compares
`timescale 1ns / 100ps
`default_nettype none
module acm_checker
   import acm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);
   localparam int NODES = 256;

   // predicted trie and text state
   logic [7:0] trie_parent [NODES];
   logic [7:0] trie_symbol [NODES];
   logic [7:0] trie_fail [NODES];
   bit         trie_end [NODES];
   int         trie_size;
   int         word_cursor;
   int         text_cursor;
   bit         text_hit;
   int         walk_queue [NODES];

   rsp_type    expected_rsp [$];

   function automatic int find_child(int p, logic [7:0] c);
      for (int i = 1; i < trie_size && i < NODES; i++) begin
         if (trie_parent[i] == p && trie_symbol[i] == c) return i;
      end
      return 0;
   endfunction

   // breadth first failure links, end marks follow the links
   task automatic link_trie();
      int head;
      int tail;
      int cur;
      int f;
      int nxt;
      int guard;
      head = 0;
      tail = 0;
      trie_fail[0] = 0;
      for (int i = 1; i < trie_size && i < NODES; i++) begin
         if (trie_parent[i] == 0) begin
            trie_fail[i] = 0;
            walk_queue[tail++] = i;
         end
      end
      while (head < tail) begin
         cur = walk_queue[head++];
         for (int i = 1; i < trie_size && i < NODES; i++) begin
            if (trie_parent[i] != cur) continue;
            f = trie_fail[cur];
            guard = 0;
            while (f != 0 && find_child(f, trie_symbol[i]) == 0 && guard < NODES) begin
               f = trie_fail[f];
               guard++;
            end
            nxt = find_child(f, trie_symbol[i]);
            trie_fail[i] = (nxt != i) ? nxt[7:0] : 8'd0;
            if (trie_end[trie_fail[i]]) trie_end[i] = 1'b1;
            if (tail < NODES) walk_queue[tail++] = i;
         end
      end
   endtask

   // one request in, one predicted response out
   task automatic predict_rsp(input req_type rq, output rsp_type rs);
      int nxt;
      int guard;
      rs.matched = text_hit;
      rs.status = 1'b0;
      case (rq.command)
         CMD_INSERT: begin
            nxt = find_child(word_cursor, rq.symbol);
            if (nxt == 0) begin
               if (trie_size >= NODES) begin
                  rs.status = 1'b1;
               end else begin
                  nxt = trie_size++;
                  trie_parent[nxt] = word_cursor[7:0];
                  trie_symbol[nxt] = rq.symbol;
                  trie_end[nxt] = 1'b0;
               end
            end
            if (nxt != 0) word_cursor = nxt;
         end
         CMD_END_WORD: begin
            if (word_cursor != 0) begin
               trie_end[word_cursor] = 1'b1;
               word_cursor = 0;
            end
         end
         CMD_BUILD: link_trie();
         CMD_SCAN: begin
            guard = 0;
            while (text_cursor != 0 && find_child(text_cursor, rq.symbol) == 0
                   && guard < NODES) begin
               text_cursor = trie_fail[text_cursor];
               guard++;
            end
            nxt = find_child(text_cursor, rq.symbol);
            if (nxt != 0) text_cursor = nxt;
            if (trie_end[text_cursor]) text_hit = 1'b1;
            rs.matched = text_hit;
         end
         CMD_END_TEXT: begin
            text_cursor = 0;
            text_hit = 1'b0;
         end
         default: ;
      endcase
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i < NODES; i++) trie_end[i] = 1'b0;
         trie_size = 1;
         word_cursor = 0;
         text_cursor = 0;
         text_hit = 1'b0;
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_rsp(req_data, want);
            expected_rsp.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (got.matched !== want.matched) begin
                  $error("matched: expected %0d, got %0d", want.matched, got.matched);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_rsp.size();
   end
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// testbench top for the pattern matcher: stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import acm_pkg::*;

   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_MID = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 800;
   localparam int NODE_BOUND = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   fail_count;
   int   pending;
   int   sent = 0;
   int   node_bound = 1;
   bit   links_stale = 1'b0;

   acm_stream_if #(.payload_type(req_type)) req ();
   acm_stream_if #(.payload_type(rsp_type)) rsp ();

   aho_corasick_matcher_top dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   acm_checker chk (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_data(req.data),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .rsp_data(rsp.data),
      .fail_count(fail_count),
      .pending(pending)
   );

   always #2 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   // one request, with a random gap before it
   task automatic send_req(input logic [2:0] cmd, input logic [7:0] sym);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= '{command: cmd, symbol: sym};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
      if (cmd == CMD_INSERT) begin
         node_bound++;
         links_stale = 1'b1;
      end
      if (cmd == CMD_BUILD) links_stale = 1'b0;
   endtask

   // mostly a tiny alphabet so that words overlap, sometimes any byte
   function automatic logic [7:0] pick_symbol();
      if ($urandom_range(0, 99) < 80) return 8'h61 + 8'($urandom_range(0, 3));
      return 8'($urandom);
   endfunction

   task automatic scan_text(input int len);
      if (links_stale) send_req(CMD_BUILD, 8'($urandom));
      repeat (len) send_req(CMD_SCAN, pick_symbol());
      send_req(CMD_END_TEXT, 8'($urandom));
   endtask

   // response side stalls
   always @(posedge clock) begin
      int stall;
      if (!reset) begin
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   // overall limit
   initial begin
      #100_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int r;
      int wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: overlapping words, extreme bytes, spare codes, empty word
      send_req(CMD_END_WORD, 8'h00);
      send_req(CMD_INSERT, 8'h68);
      send_req(CMD_INSERT, 8'h65);
      send_req(CMD_END_WORD, 8'h00);
      send_req(CMD_INSERT, 8'h73);
      send_req(CMD_INSERT, 8'h68);
      send_req(CMD_INSERT, 8'h65);
      send_req(CMD_END_WORD, 8'hff);
      send_req(CMD_INSERT, 8'h00);
      send_req(CMD_INSERT, 8'hff);
      send_req(CMD_END_WORD, 8'h00);
      send_req(CMD_END_WORD, 8'h00);
      send_req(CMD_SPARE_LO, 8'hff);
      send_req(CMD_SPARE_MID, 8'h00);
      send_req(CMD_SPARE_HI, 8'h5a);
      send_req(CMD_BUILD, 8'h00);
      send_req(CMD_SCAN, 8'h75);
      send_req(CMD_SCAN, 8'h73);
      send_req(CMD_SCAN, 8'h68);
      send_req(CMD_SCAN, 8'h65);
      send_req(CMD_SCAN, 8'h00);
      send_req(CMD_END_TEXT, 8'h00);
      send_req(CMD_SCAN, 8'h00);
      send_req(CMD_SCAN, 8'hff);
      send_req(CMD_END_TEXT, 8'hff);

      // random: word sets, texts, noise
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 8) quiet = ~quiet;
         if (sent > RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 30) begin
            // drop the request line and let every response come back
            req.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 12) begin
            case ($urandom_range(0, 3))
               0: send_req(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 8'($urandom));
               1: send_req(CMD_END_WORD, 8'($urandom));
               2: send_req(CMD_BUILD, 8'($urandom));
               default: if (node_bound < NODE_BOUND) send_req(CMD_INSERT, pick_symbol());
            endcase
         end else if (r < 30 && node_bound < NODE_BOUND) begin
            repeat ($urandom_range(1, 3)) begin
               repeat ($urandom_range(1, 4)) send_req(CMD_INSERT, pick_symbol());
               send_req(CMD_END_WORD, 8'($urandom));
            end
            send_req(CMD_BUILD, 8'($urandom));
         end else begin
            scan_text($urandom_range(1, 12));
         end
      end

      // fill the node table with one long chain, then overflow it
      quiet = 1'b0;
      repeat (250) send_req(CMD_INSERT, 8'ha5);
      send_req(CMD_INSERT, 8'h3c);
      send_req(CMD_END_WORD, 8'h00);
      send_req(CMD_BUILD, 8'h00);
      repeat (6) send_req(CMD_SCAN, 8'ha5);
      send_req(CMD_END_TEXT, 8'h00);
      send_req(CMD_INSERT, 8'h7e);
      send_req(CMD_END_TEXT, 8'h00);
      @(posedge clock);
      req.valid <= 1'b0;

      // drain, then let the block settle
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 2_000_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
`default_nettype wire
